/* design/cartridge_prg_bank_mapper_macros.svh */
// ----------------------------------------------------------------------------
// cartridge_prg_bank_mapper_macros.svh
// Assertion macros used by the mapper sequencer.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_PRG_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_PRG_BANK_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cpbm_pkg.sv */
// ----------------------------------------------------------------------------
// cpbm_pkg
// Types, register addresses and codes of the program bank mapper.
// ----------------------------------------------------------------------------
package cpbm_pkg;

    localparam int ROM_ADDR_BITS = 20;
    localparam int RAM_BANKS     = 8;
    localparam int PHYS_W        = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [1:0] MODE_REG   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_LAYOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK   = 2'd1;

    localparam logic [2:0] LAYOUT_NONE = 3'd0;
    localparam logic [2:0] LAYOUT_8K   = 3'd1;
    localparam logic [2:0] LAYOUT_16K  = 3'd2;
    localparam logic [2:0] LAYOUT_32K  = 3'd3;
    localparam logic [2:0] LAYOUT_40K  = 3'd4;
    localparam logic [2:0] LAYOUT_64K  = 3'd5;

    localparam logic [1:0] BMODE_32K  = 2'd0;
    localparam logic [1:0] BMODE_16K  = 2'd1;
    localparam logic [1:0] BMODE_16_8 = 2'd2;
    localparam logic [1:0] BMODE_8K   = 2'd3;

    localparam logic [15:0] ADDR_MODE   = 16'h5100;
    localparam logic [15:0] ADDR_KEY0   = 16'h5102;
    localparam logic [15:0] ADDR_KEY1   = 16'h5103;
    localparam logic [15:0] ADDR_WINDOW = 16'h5113;
    localparam logic [15:0] ADDR_BANK0  = 16'h5114;
    localparam logic [15:0] ADDR_BANK1  = 16'h5115;
    localparam logic [15:0] ADDR_BANK2  = 16'h5116;
    localparam logic [15:0] ADDR_BANK3  = 16'h5117;
    localparam logic [15:0] ADDR_MUL_LO = 16'h5205;
    localparam logic [15:0] ADDR_MUL_HI = 16'h5206;
    localparam logic [15:0] ADDR_BANKED = 16'h6000;
    localparam logic [15:0] ADDR_ROM    = 16'h8000;

    localparam logic [1:0] KEY0_UNLOCK = 2'd2;
    localparam logic [1:0] KEY1_UNLOCK = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] bus_addr;
        logic [7:0]  wdata;
    } t_in;

    typedef struct packed {
        logic              mapped;
        logic              to_ram;
        logic [PHYS_W-1:0] phys_addr;
        logic              write_ok;
        logic              rdata_valid;
        logic [7:0]        rdata;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
        logic remap;
        logic cfg_we;
    } t_cmd;

    typedef struct packed {
        logic remap_req;
    } t_stat;

endpackage

/* design/cartridge_prg_bank_mapper.sv */
// ----------------------------------------------------------------------------
// cartridge_prg_bank_mapper
// Program-space bank switching: register writes, address translation to ROM
// or work RAM, RAM write protection and the 8 x 8 multiplier readback.
//
//   Channel   Handshake                       Payload
//   request   i_start / o_busy                i_in  (t_in)
//   result    o_res_valid (one-cycle strobe)  o_res (t_out)
//   config    i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// A beat is loaded, then executed; the result strobe follows from a register,
// and during it the next beat may already be accepted unless a remap pass runs.
// A write that changes the bank mode or a slot register adds a remap pass; a
// configuration write is followed by a remap pass. Reset is synchronous; there
// is no clearing pass. The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module cartridge_prg_bank_mapper #(
    parameter int ROM_ADDR_BITS = cpbm_pkg::ROM_ADDR_BITS,
    parameter int RAM_BANKS     = cpbm_pkg::RAM_BANKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  cpbm_pkg::t_in                   i_in,
    output logic                            o_res_valid,
    output cpbm_pkg::t_out                  o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cpbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cpbm_pkg::t_cmd  cmd;
    cpbm_pkg::t_stat stat;

    cpbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_cfg_ready (o_cfg_ready),
        .o_res_valid (o_res_valid)
    );

    cpbm_datapath #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .RAM_BANKS     (RAM_BANKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res)
    );

endmodule

/* design/cpbm_ctrl.sv */
// ----------------------------------------------------------------------------
// cpbm_ctrl
// Sequencer: accepts a beat, executes it, and runs a remap pass when needed.
// ----------------------------------------------------------------------------
`include "cartridge_prg_bank_mapper_macros.svh"

module cpbm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_cfg_valid,
    input  cpbm_pkg::t_stat i_stat,
    output cpbm_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_cfg_ready,
    output logic           o_res_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REMAP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;
    logic   n_res_valid;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_res_valid  = 1'b0;
        o_cfg_ready  = (r_state == ST_IDLE) && !i_start;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end else if (i_cfg_valid) begin
                    o_cmd.cfg_we = 1'b1;
                    n_state      = ST_REMAP;
                end
            end
            ST_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_res_valid = 1'b1;
                n_state     = i_stat.remap_req ? ST_REMAP : ST_IDLE;
            end
            ST_REMAP: begin
                o_cmd.remap = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;

    `CPBM_ASSERT_NEXT(a_strobe_single, r_res_valid, !r_res_valid, "result strobe held")
    `CPBM_ASSERT_NEXT(a_start_exec, i_start && (r_state == ST_IDLE), r_state == ST_EXEC, "no execute")
    `CPBM_ASSERT_NEXT(a_exec_strobe, r_state == ST_EXEC, r_res_valid, "execute gave no result")
    `CPBM_ASSERT_NEXT(a_cfg_remap, i_cfg_valid && o_cfg_ready, r_state == ST_REMAP, "no remap")
    `CPBM_ASSERT_NOW(a_ready_idle, o_cfg_ready, !o_busy && !o_cmd.load, "ready while busy")

endmodule

/* design/cpbm_datapath.sv */
// ----------------------------------------------------------------------------
// cpbm_datapath
// Mapper registers, slot mapping, address translation and the multiplier.
// ----------------------------------------------------------------------------
module cpbm_datapath #(
    parameter int ROM_ADDR_BITS = cpbm_pkg::ROM_ADDR_BITS,
    parameter int RAM_BANKS     = cpbm_pkg::RAM_BANKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cpbm_pkg::t_cmd                     i_cmd,
    output cpbm_pkg::t_stat                    o_stat,
    input  cpbm_pkg::t_in                      i_in,
    input  logic [cpbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpbm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output cpbm_pkg::t_out                     o_res
);

    localparam int PHYS_W = cpbm_pkg::PHYS_W;
    localparam logic [PHYS_W:0] ROM_SPAN = (PHYS_W + 1)'(1) << ROM_ADDR_BITS;
    localparam logic [PHYS_W-1:0] ROM_MASK = PHYS_W'(ROM_SPAN - (PHYS_W + 1)'(1));

    typedef struct packed {
        logic       is_ram;
        logic [2:0] ram_bank;
        logic [6:0] rom;
    } t_slot;

    typedef struct packed {
        logic       ok;
        logic [2:0] bank;
    } t_lookup;

    function automatic t_lookup ram_lookup(input logic [2:0] layout, input logic [2:0] idx);
        t_lookup lk;
        lk.ok   = 1'b1;
        lk.bank = '0;
        case (layout)
            cpbm_pkg::LAYOUT_8K: begin
                lk.ok = !idx[2];
            end
            cpbm_pkg::LAYOUT_16K: begin
                lk.bank = {2'b00, idx[2]};
            end
            cpbm_pkg::LAYOUT_32K: begin
                lk.ok   = !idx[2];
                lk.bank = idx;
            end
            cpbm_pkg::LAYOUT_40K: begin
                lk.bank = idx[2] ? 3'd4 : idx;
            end
            cpbm_pkg::LAYOUT_64K: begin
                lk.bank = idx;
            end
            default: begin
                lk.ok = 1'b0;
            end
        endcase
        if (int'(lk.bank) >= RAM_BANKS) begin
            lk.ok = 1'b0;
        end
        return lk;
    endfunction

    function automatic logic [6:0] limit_bank(input logic [6:0] v, input logic [6:0] lim);
        return (v > lim) ? (v & lim) : v;
    endfunction

    function automatic t_slot map8(input t_slot cur, input logic [7:0] v,
                                   input logic [2:0] layout, input logic [6:0] mask);
        t_slot   s;
        t_lookup lk;
        s  = cur;
        lk = ram_lookup(layout, v[2:0]);
        if (v[7]) begin
            s.is_ram = 1'b0;
            s.rom    = limit_bank(v[6:0], mask);
        end else if (lk.ok) begin
            s.is_ram   = 1'b1;
            s.ram_bank = lk.bank;
        end
        return s;
    endfunction

    cpbm_pkg::t_in  r_in;
    cpbm_pkg::t_out r_res;
    cpbm_pkg::t_out n_res;

    logic [2:0]  r_ram_layout;
    logic [6:0]  r_rom_mask;
    logic [1:0]  r_bank_mode;
    logic [7:0]  r_bank_regs [4];
    t_slot       r_slot [4];
    t_slot       n_slot [4];
    logic [2:0]  r_win_bank;
    logic [1:0]  r_key0;
    logic [1:0]  r_key1;
    logic        r_unlocked;
    logic [7:0]  r_fac0;
    logic [7:0]  r_fac1;
    logic [15:0] r_product;

    t_lookup     lk_win;
    t_lookup     lk_lo;
    t_lookup     lk_hi;
    t_slot       low0;
    t_slot       low1;
    t_slot       last;
    logic [6:0]  b32;
    logic [6:0]  b16_lo;
    logic [6:0]  b16_hi;
    t_slot       s_sel;
    logic        layout_has_ram;

    // Slot mapping pass, taken from the current mapping, registers and configuration.
    always_comb begin
        lk_lo  = ram_lookup(r_ram_layout, {r_bank_regs[1][2:1], 1'b0});
        lk_hi  = ram_lookup(r_ram_layout, {r_bank_regs[1][2:1], 1'b1});
        b32    = limit_bank({2'b00, r_bank_regs[3][6:2]}, {2'b00, r_rom_mask[6:2]});
        b16_lo = limit_bank({1'b0, r_bank_regs[1][6:1]}, {1'b0, r_rom_mask[6:1]});
        b16_hi = limit_bank({1'b0, r_bank_regs[3][6:1]}, {1'b0, r_rom_mask[6:1]});

        low0 = r_slot[0];
        low1 = r_slot[1];
        if (r_bank_regs[1][7]) begin
            low0.is_ram = 1'b0;
            low0.rom    = {b16_lo[5:0], 1'b0};
            low1.is_ram = 1'b0;
            low1.rom    = {b16_lo[5:0], 1'b1};
        end else begin
            if (lk_lo.ok) begin
                low0.is_ram   = 1'b1;
                low0.ram_bank = {r_bank_regs[1][2:1], 1'b0};
            end
            if (lk_hi.ok) begin
                low1.is_ram   = 1'b1;
                low1.ram_bank = {r_bank_regs[1][2:1], 1'b1};
            end
        end

        last        = r_slot[3];
        last.is_ram = 1'b0;
        last.rom    = limit_bank(r_bank_regs[3][6:0], r_rom_mask);

        n_slot = r_slot;
        case (r_bank_mode)
            cpbm_pkg::BMODE_32K: begin
                if (r_rom_mask >= 7'd3) begin
                    for (int i = 0; i < 4; i++) begin
                        n_slot[i].is_ram = 1'b0;
                        n_slot[i].rom    = {b32[4:0], 2'(i)};
                    end
                end
            end
            cpbm_pkg::BMODE_16K: begin
                if (r_rom_mask != 7'd0) begin
                    n_slot[0]        = low0;
                    n_slot[1]        = low1;
                    n_slot[2].is_ram = 1'b0;
                    n_slot[2].rom    = {b16_hi[5:0], 1'b0};
                    n_slot[3].is_ram = 1'b0;
                    n_slot[3].rom    = {b16_hi[5:0], 1'b1};
                end
            end
            cpbm_pkg::BMODE_16_8: begin
                if (r_rom_mask != 7'd0) begin
                    n_slot[0] = low0;
                    n_slot[1] = low1;
                end
                n_slot[2] = map8(r_slot[2], r_bank_regs[2], r_ram_layout, r_rom_mask);
                n_slot[3] = last;
            end
            default: begin
                n_slot[0] = map8(r_slot[0], r_bank_regs[0], r_ram_layout, r_rom_mask);
                n_slot[1] = map8(r_slot[1], r_bank_regs[1], r_ram_layout, r_rom_mask);
                n_slot[2] = map8(r_slot[2], r_bank_regs[2], r_ram_layout, r_rom_mask);
                n_slot[3] = last;
            end
        endcase
    end

    // Translation of the held beat against the current state.
    always_comb begin
        n_res          = '0;
        s_sel          = r_slot[r_in.bus_addr[14:13]];
        layout_has_ram = (r_ram_layout >= cpbm_pkg::LAYOUT_8K)
                         && (r_ram_layout <= cpbm_pkg::LAYOUT_64K);
        lk_win         = ram_lookup(r_ram_layout, r_in.wdata[2:0]);
        if ((r_in.mode == cpbm_pkg::MODE_READ) || (r_in.mode == cpbm_pkg::MODE_WRITE)) begin
            if (r_in.bus_addr >= cpbm_pkg::ADDR_BANKED) begin
                n_res.mapped = 1'b1;
                if (r_in.bus_addr < cpbm_pkg::ADDR_ROM) begin
                    n_res.to_ram    = 1'b1;
                    n_res.phys_addr = {4'b0000, r_win_bank, r_in.bus_addr[12:0]};
                    n_res.write_ok  = (r_in.mode == cpbm_pkg::MODE_WRITE) && r_unlocked
                                      && layout_has_ram;
                end else if (s_sel.is_ram) begin
                    n_res.to_ram    = 1'b1;
                    n_res.phys_addr = {4'b0000, s_sel.ram_bank, r_in.bus_addr[12:0]};
                    n_res.write_ok  = (r_in.mode == cpbm_pkg::MODE_WRITE) && r_unlocked;
                end else begin
                    n_res.phys_addr = {s_sel.rom, r_in.bus_addr[12:0]} & ROM_MASK;
                end
            end else if (r_in.mode == cpbm_pkg::MODE_READ) begin
                if (r_in.bus_addr == cpbm_pkg::ADDR_MUL_LO) begin
                    n_res.rdata_valid = 1'b1;
                    n_res.rdata       = r_product[7:0];
                end else if (r_in.bus_addr == cpbm_pkg::ADDR_MUL_HI) begin
                    n_res.rdata_valid = 1'b1;
                    n_res.rdata       = r_product[15:8];
                end
            end
        end
    end

    always_comb begin
        o_stat.remap_req = 1'b0;
        if (r_in.mode == cpbm_pkg::MODE_REG) begin
            if (r_in.bus_addr == cpbm_pkg::ADDR_MODE) begin
                o_stat.remap_req = (r_in.wdata[1:0] != r_bank_mode);
            end else if ((r_in.bus_addr >= cpbm_pkg::ADDR_BANK0)
                         && (r_in.bus_addr <= cpbm_pkg::ADDR_BANK3)) begin
                o_stat.remap_req = (r_bank_regs[r_in.bus_addr[1:0]] != r_in.wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_layout <= cpbm_pkg::LAYOUT_NONE;
            r_rom_mask   <= 7'h7F;
            r_bank_mode  <= cpbm_pkg::BMODE_8K;
            for (int i = 0; i < 4; i++) begin
                r_bank_regs[i] <= 8'hFF;
                r_slot[i]      <= '{is_ram: 1'b0, ram_bank: 3'd0, rom: 7'h7F};
            end
            r_win_bank <= '0;
            r_key0     <= '0;
            r_key1     <= '0;
            r_unlocked <= 1'b0;
            r_fac0     <= '0;
            r_fac1     <= '0;
            r_product  <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                case (i_cfg_index)
                    cpbm_pkg::CFG_RAM_LAYOUT: r_ram_layout <= i_cfg_data[2:0];
                    cpbm_pkg::CFG_ROM_MASK:   r_rom_mask   <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec && (r_in.mode == cpbm_pkg::MODE_REG)) begin
                case (r_in.bus_addr)
                    cpbm_pkg::ADDR_MODE: begin
                        r_bank_mode <= r_in.wdata[1:0];
                    end
                    cpbm_pkg::ADDR_KEY0: begin
                        r_key0     <= r_in.wdata[1:0];
                        r_unlocked <= (r_in.wdata[1:0] == cpbm_pkg::KEY0_UNLOCK)
                                      && (r_key1 == cpbm_pkg::KEY1_UNLOCK);
                    end
                    cpbm_pkg::ADDR_KEY1: begin
                        r_key1     <= r_in.wdata[1:0];
                        r_unlocked <= (r_key0 == cpbm_pkg::KEY0_UNLOCK)
                                      && (r_in.wdata[1:0] == cpbm_pkg::KEY1_UNLOCK);
                    end
                    cpbm_pkg::ADDR_WINDOW: begin
                        if (lk_win.ok) begin
                            r_win_bank <= lk_win.bank;
                        end
                    end
                    cpbm_pkg::ADDR_BANK0, cpbm_pkg::ADDR_BANK1,
                    cpbm_pkg::ADDR_BANK2, cpbm_pkg::ADDR_BANK3: begin
                        r_bank_regs[r_in.bus_addr[1:0]] <= r_in.wdata;
                    end
                    cpbm_pkg::ADDR_MUL_LO: begin
                        r_fac0    <= r_in.wdata;
                        r_product <= 16'(r_in.wdata) * 16'(r_fac1);
                    end
                    cpbm_pkg::ADDR_MUL_HI: begin
                        r_fac1    <= r_in.wdata;
                        r_product <= 16'(r_fac0) * 16'(r_in.wdata);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.remap) begin
                r_slot <= n_slot;
            end
        end
    end

    assign o_res = r_res;

endmodule

/* verif/tb_cartridge_prg_bank_mapper.sv */
// ----------------------------------------------------------------------------
// tb_cartridge_prg_bank_mapper
// Self-checking bench for the program bank mapper. A behavioural model of the
// bank registers, write protection and multiplier predicts every translation.
// Each result beat is compared field by field with the oldest prediction.
// Directed checks of the special cases come first, then a sweep of board
// settings, then constrained random bus traffic with random idle gaps or back to back.
// ----------------------------------------------------------------------------
module tb_cartridge_prg_bank_mapper;

    import cpbm_pkg::*;

    localparam logic [PHYS_W-1:0] ROM_PHYS_MASK = PHYS_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in                   i_in;
    logic                  o_res_valid;
    t_out                  o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cartridge_prg_bank_mapper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    logic [2:0]  board_layout;
    logic [6:0]  board_rom_mask;
    logic [1:0]  cur_bank_mode;
    logic [7:0]  slot_reg [4];
    logic        slot_in_ram [4];
    logic [15:0] slot_ram_base [4];
    logic [6:0]  slot_rom_bank [4];
    logic [2:0]  window_bank;
    logic [1:0]  protect_key [2];
    logic        ram_unlocked;
    logic [7:0]  mul_factor [2];
    logic [15:0] mul_product;

    t_out pending_translations [$];
    int   mismatch_count;
    logic back_to_back;

    function automatic logic ram_bank_of(input logic [7:0] v, output logic [2:0] bank);
        int idx;
        int b;
        idx = v[2:0];
        b   = -1;
        case (board_layout)
            LAYOUT_8K:  if (idx < 4) b = 0;
            LAYOUT_16K: b = idx >> 2;
            LAYOUT_32K: if (idx < 4) b = idx;
            LAYOUT_40K: b = (idx < 4) ? idx : 4;
            LAYOUT_64K: b = idx;
            default:    b = -1;
        endcase
        bank = b[2:0];
        return (b >= 0) && (b < RAM_BANKS);
    endfunction

    function automatic logic [6:0] clamp_bank(input int v, input int lim);
        int r;
        r = (v > lim) ? (v & lim) : v;
        return r[6:0];
    endfunction

    function automatic void map_slot8(input int s);
        logic [2:0] bank;
        logic [7:0] v;
        v = slot_reg[s];
        if (v[7]) begin
            slot_in_ram[s]   = 1'b0;
            slot_rom_bank[s] = clamp_bank(v[6:0], board_rom_mask);
        end else if (ram_bank_of(v, bank)) begin
            slot_in_ram[s]   = 1'b1;
            slot_ram_base[s] = {bank, 13'd0};
        end
    endfunction

    function automatic void map_rom16(input int s, input logic [7:0] v);
        logic [6:0] b;
        b = clamp_bank(v[6:1], board_rom_mask >> 1);
        slot_in_ram[s]       = 1'b0;
        slot_in_ram[s+1]     = 1'b0;
        slot_rom_bank[s]     = {b[5:0], 1'b0};
        slot_rom_bank[s+1]   = {b[5:0], 1'b1};
    endfunction

    function automatic void map_lower16();
        logic [2:0] bank;
        logic [2:0] lo;
        logic [2:0] hi;
        if (slot_reg[1][7]) begin
            map_rom16(0, slot_reg[1]);
        end else begin
            lo = {slot_reg[1][2:1], 1'b0};
            hi = {slot_reg[1][2:1], 1'b1};
            if (ram_bank_of({5'd0, lo}, bank)) begin
                slot_in_ram[0]   = 1'b1;
                slot_ram_base[0] = {lo, 13'd0};
            end
            if (ram_bank_of({5'd0, hi}, bank)) begin
                slot_in_ram[1]   = 1'b1;
                slot_ram_base[1] = {hi, 13'd0};
            end
        end
    endfunction

    function automatic void remap_slots();
        logic [6:0] b;
        case (cur_bank_mode)
            BMODE_32K: begin
                if (board_rom_mask >= 3) begin
                    b = clamp_bank(slot_reg[3][6:2], board_rom_mask >> 2);
                    for (int i = 0; i < 4; i++) begin
                        slot_in_ram[i]   = 1'b0;
                        slot_rom_bank[i] = {b[4:0], i[1:0]};
                    end
                end
            end
            BMODE_16K: begin
                if (board_rom_mask >= 1) begin
                    map_lower16();
                    map_rom16(2, slot_reg[3]);
                end
            end
            BMODE_16_8: begin
                if (board_rom_mask >= 1) map_lower16();
                map_slot8(2);
                slot_in_ram[3]   = 1'b0;
                slot_rom_bank[3] = clamp_bank(slot_reg[3][6:0], board_rom_mask);
            end
            default: begin
                map_slot8(0);
                map_slot8(1);
                map_slot8(2);
                slot_in_ram[3]   = 1'b0;
                slot_rom_bank[3] = clamp_bank(slot_reg[3][6:0], board_rom_mask);
            end
        endcase
        for (int i = 0; i < 4; i++)
            if (!slot_in_ram[i]) slot_ram_base[i] = '0;
    endfunction

    function automatic void reset_mapper_state();
        board_layout   = LAYOUT_NONE;
        board_rom_mask = 7'h7F;
        cur_bank_mode  = BMODE_8K;
        for (int i = 0; i < 4; i++) begin
            slot_reg[i]      = 8'hFF;
            slot_in_ram[i]   = 1'b0;
            slot_ram_base[i] = '0;
            slot_rom_bank[i] = '0;
        end
        window_bank    = '0;
        protect_key[0] = '0;
        protect_key[1] = '0;
        ram_unlocked   = 1'b0;
        mul_factor[0]  = '0;
        mul_factor[1]  = '0;
        mul_product    = '0;
        remap_slots();
    endfunction

    function automatic void apply_board_setting(input logic [CFG_IDX_W-1:0] idx,
                                                input logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_RAM_LAYOUT) begin
            board_layout = value[2:0];
            remap_slots();
        end else if (idx == CFG_ROM_MASK) begin
            board_rom_mask = value[6:0];
            remap_slots();
        end
    endfunction

    function automatic void mapper_register_write(input logic [15:0] a, input logic [7:0] v);
        logic [2:0] bank;
        if (a == ADDR_MODE) begin
            if (v[1:0] != cur_bank_mode) begin
                cur_bank_mode = v[1:0];
                remap_slots();
            end
        end else if (a == ADDR_KEY0 || a == ADDR_KEY1) begin
            protect_key[a[0]] = v[1:0];
            ram_unlocked = (protect_key[0] == KEY0_UNLOCK) && (protect_key[1] == KEY1_UNLOCK);
        end else if (a == ADDR_WINDOW) begin
            if (ram_bank_of(v, bank)) window_bank = bank;
        end else if (a >= ADDR_BANK0 && a <= ADDR_BANK3) begin
            if (slot_reg[a[1:0]] != v) begin
                slot_reg[a[1:0]] = v;
                remap_slots();
            end
        end else if (a == ADDR_MUL_LO || a == ADDR_MUL_HI) begin
            mul_factor[a[0] ? 0 : 1] = v;
            mul_product = 16'(mul_factor[0]) * 16'(mul_factor[1]);
        end
    endfunction

    function automatic t_out predict_translation(input t_in x);
        t_out r;
        int   s;
        r = '0;
        if (x.mode == MODE_REG) begin
            if (x.bus_addr < ADDR_BANKED) mapper_register_write(x.bus_addr, x.wdata);
        end else if (x.mode == MODE_READ || x.mode == MODE_WRITE) begin
            if (x.bus_addr >= ADDR_BANKED) begin
                r.mapped = 1'b1;
                if (x.bus_addr < ADDR_ROM) begin
                    r.to_ram    = 1'b1;
                    r.phys_addr = {4'd0, window_bank, x.bus_addr[12:0]};
                    r.write_ok  = (x.mode == MODE_WRITE) && ram_unlocked &&
                                  (board_layout >= LAYOUT_8K) && (board_layout <= LAYOUT_64K);
                end else begin
                    s = x.bus_addr[14:13];
                    if (slot_in_ram[s]) begin
                        r.to_ram    = 1'b1;
                        r.phys_addr = {4'd0, slot_ram_base[s] | {3'd0, x.bus_addr[12:0]}};
                        r.write_ok  = (x.mode == MODE_WRITE) && ram_unlocked;
                    end else begin
                        r.phys_addr = {slot_rom_bank[s], x.bus_addr[12:0]} & ROM_PHYS_MASK;
                    end
                end
            end else if (x.mode == MODE_READ && x.bus_addr == ADDR_MUL_LO) begin
                r.rdata_valid = 1'b1;
                r.rdata       = mul_product[7:0];
            end else if (x.mode == MODE_READ && x.bus_addr == ADDR_MUL_HI) begin
                r.rdata_valid = 1'b1;
                r.rdata       = mul_product[15:8];
            end
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input t_out want, input t_out got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected map=%0d ram=%0d phys=%05h wok=%0d rv=%0d rd=%02h,",
                     what, want.mapped, want.to_ram, want.phys_addr, want.write_ok,
                     want.rdata_valid, want.rdata,
                     " got map=%0d ram=%0d phys=%05h wok=%0d rv=%0d rd=%02h",
                     got.mapped, got.to_ram, got.phys_addr,
                     got.write_ok, got.rdata_valid, got.rdata);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_res_valid) begin
            if (pending_translations.size() == 0) begin
                log_mismatch("unexpected result", '0, o_res);
            end else begin
                want = pending_translations.pop_front();
                if (want.mapped !== o_res.mapped || want.to_ram !== o_res.to_ram ||
                    want.phys_addr !== o_res.phys_addr || want.write_ok !== o_res.write_ok ||
                    want.rdata_valid !== o_res.rdata_valid || want.rdata !== o_res.rdata)
                    log_mismatch("mismatch", want, o_res);
            end
        end
    end

    task automatic bus_beat(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [7:0] data);
        t_in item;
        int  gap;
        item.mode     = mode;
        item.bus_addr = addr;
        item.wdata    = data;
        gap = back_to_back ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (o_busy);
        pending_translations.push_back(predict_translation(item));
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_translations.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_board_config(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_board_setting(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_board_config();
        logic [6:0] mask;
        if ($urandom_range(0, 3) != 0) mask = (7'd1 << $urandom_range(0, 7)) - 7'd1;
        else mask = 7'($urandom_range(0, 127));
        write_board_config(CFG_RAM_LAYOUT, {5'd0, 3'($urandom_range(0, 5))});
        write_board_config(CFG_ROM_MASK, {1'b0, mask});
    endtask

    task automatic random_bus_beat();
        int         pick;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        v    = 8'($urandom_range(0, 255));
        if (pick < 35) begin
            case ($urandom_range(0, 6))
                0: bus_beat(MODE_REG, ADDR_MODE, v);
                1: bus_beat(MODE_REG, ADDR_KEY0,
                            ($urandom_range(0, 9) < 7) ? {v[7:2], KEY0_UNLOCK} : v);
                2: bus_beat(MODE_REG, ADDR_KEY1,
                            ($urandom_range(0, 9) < 7) ? {v[7:2], KEY1_UNLOCK} : v);
                3: bus_beat(MODE_REG, ADDR_WINDOW, v);
                4: bus_beat(MODE_REG, ADDR_BANK0 + 16'($urandom_range(0, 3)), v);
                5: bus_beat(MODE_REG, ADDR_MUL_LO, v);
                default: bus_beat(MODE_REG, ADDR_MUL_HI, v);
            endcase
        end else if (pick < 80) begin
            bus_beat($urandom_range(0, 1) ? MODE_READ : MODE_WRITE,
                     16'($urandom_range(16'h6000, 16'hFFFF)), v);
        end else if (pick < 88) begin
            bus_beat(MODE_READ, $urandom_range(0, 1) ? ADDR_MUL_LO : ADDR_MUL_HI, v);
        end else begin
            bus_beat(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), v);
        end
    endtask

    task automatic test_reset_state();
        bus_beat(MODE_READ, ADDR_BANKED, 8'h00);
        bus_beat(MODE_WRITE, 16'hFFFF, 8'hFF);
        bus_beat(MODE_READ, ADDR_MUL_HI, 8'h00);
    endtask

    task automatic test_write_protect();
        write_board_config(CFG_RAM_LAYOUT, {5'd0, LAYOUT_64K});
        bus_beat(MODE_REG, ADDR_KEY0, {6'd0, KEY0_UNLOCK});
        bus_beat(MODE_REG, ADDR_KEY1, {6'd0, KEY1_UNLOCK});
        bus_beat(MODE_REG, ADDR_WINDOW, 8'h07);
        bus_beat(MODE_WRITE, 16'h7FFF, 8'hA5);
        bus_beat(MODE_REG, ADDR_BANK0, 8'h05);
        bus_beat(MODE_WRITE, ADDR_ROM, 8'h00);
        bus_beat(MODE_REG, ADDR_KEY1, 8'h00);
        bus_beat(MODE_WRITE, ADDR_ROM, 8'h5A);
    endtask

    task automatic test_bank_modes();
        bus_beat(MODE_REG, ADDR_MODE, {6'd0, BMODE_32K});
        bus_beat(MODE_READ, 16'hE000, 8'h00);
        bus_beat(MODE_REG, ADDR_MODE, {6'd0, BMODE_16K});
        bus_beat(MODE_REG, ADDR_BANK1, 8'h03);
        bus_beat(MODE_READ, 16'hA000, 8'h00);
        bus_beat(MODE_REG, ADDR_MODE, {6'd0, BMODE_16_8});
        bus_beat(MODE_REG, ADDR_BANK1, 8'h03);
        bus_beat(MODE_READ, 16'hFFFF, 8'h00);
    endtask

    task automatic test_small_boards();
        write_board_config(CFG_RAM_LAYOUT, {5'd0, LAYOUT_8K});
        bus_beat(MODE_REG, ADDR_WINDOW, 8'h04);
        bus_beat(MODE_READ, 16'h7000, 8'h00);
        write_board_config(CFG_ROM_MASK, 8'h01);
        bus_beat(MODE_REG, ADDR_MODE, {6'd0, BMODE_32K});
        bus_beat(MODE_READ, ADDR_ROM, 8'h00);
    endtask

    task automatic test_multiplier_and_ignored();
        bus_beat(MODE_REG, ADDR_MUL_LO, 8'hFF);
        bus_beat(MODE_REG, ADDR_MUL_HI, 8'hFF);
        bus_beat(MODE_READ, ADDR_MUL_LO, 8'h00);
        bus_beat(MODE_REG, 16'hFFFF, 8'h80);
        bus_beat(MODE_WRITE, ADDR_MUL_LO, 8'h12);
    endtask

    task automatic test_config_sweep();
        logic [6:0] mask;
        for (int layout = 0; layout <= 5; layout++) begin
            case (layout)
                0: mask = 7'h00;
                1: mask = 7'h01;
                2: mask = 7'h03;
                3: mask = 7'h07;
                4: mask = 7'h7F;
                default: mask = 7'($urandom_range(0, 127));
            endcase
            write_board_config(CFG_RAM_LAYOUT, layout[7:0]);
            write_board_config(CFG_ROM_MASK, {1'b0, mask});
            repeat (10) random_bus_beat();
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 9; seg++) begin
            back_to_back = (seg % 3 == 1);
            if (seg % 2 == 0) random_board_config();
            else wait_until_drained();
            repeat (38) random_bus_beat();
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        reset_mapper_state();
        mismatch_count = 0;
        back_to_back   = 1'b0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_in           = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_write_protect();
        test_bank_modes();
        test_small_boards();
        test_multiplier_and_ignored();
        test_config_sweep();
        test_random_traffic();

        wait_until_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_translations.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
